### rtl/msrp_pkg.sv
// Shared types and constants for the modular square root block.
// No dependencies; used by every file in rtl/.
package msrp_pkg;

  localparam int WIDTH_DEF = 64;
  localparam int NR_LIMIT  = 4096;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONRES = 2'd1;
  localparam logic [1:0] ST_BADMOD = 2'd2;

  typedef struct packed {
    logic [63:0] value_in;
    logic [63:0] prime_modulus;
  } in_t;

  typedef struct packed {
    logic [63:0] root_out;
    logic [1:0]  status;
  } out_t;

endpackage

### rtl/msrp_mulmod.sv
// Bit-serial modular multiplier: res = x * y mod m, MSB of y first.
// Depends on msrp_pkg for the default width; x, y < m and m >= 2 assumed.
module msrp_mulmod #(
  parameter int WIDTH = msrp_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] res
);

  localparam int CW = $clog2(WIDTH);

  logic             busy_r, busy_nxt;
  logic             add_r, add_nxt;     // 0: doubling step, 1: add-x step
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] x_r, y_r, m_r;
  logic [WIDTH-1:0] opnd;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] red;
  logic             last;

  // one modular add per cycle: operands below m, so one subtract is enough
  assign opnd = add_r ? x_r : acc_r;
  assign sum  = {1'b0, acc_r} + {1'b0, opnd};
  assign red  = (sum >= {1'b0, m_r}) ? WIDTH'(sum - {1'b0, m_r}) : sum[WIDTH-1:0];
  assign last = (cnt_r == '0);

  always_comb begin
    busy_nxt = busy_r;
    add_nxt  = add_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      add_nxt  = 1'b0;
      cnt_nxt  = CW'(WIDTH - 1);
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = red;
      if (!add_r && y_r[cnt_r]) begin
        add_nxt = 1'b1;
      end else begin
        add_nxt = 1'b0;
        if (last) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    add_r <= add_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    if (start) begin
      x_r <= x;
      y_r <= y;
      m_r <= m;
    end
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

### rtl/modular_square_root_prime_top.sv
// Modular square root modulo a prime (Tonelli-Shanks), top level.
// Depends on msrp_pkg and msrp_mulmod.
//
// One transfer in gives one transfer out: a root of value_in modulo
// prime_modulus, or status 1 (non-residue) or 2 (bad modulus: below 2,
// no non-residue found below 4096, or squaring loop fails, as for a
// composite modulus). Only the low WIDTH bits of each field are used.
// Items are handled one at a time; in_stall is high from the accepting
// edge until the result has been loaded into the output register, and
// the next item may be accepted while that result still waits.
// The input is first reduced bit by bit; then every modular product
// runs in the single bit-serial multiplier, issue and handoff included,
// and each exponentiation takes up to 2*WIDTH products. Tonelli-Shanks
// adds one exponentiation per non-residue candidate and further products
// per outer pass, and a composite modulus that passes Euler's test may
// walk all candidates up to 4096.
module modular_square_root_prime_top #(
  parameter int WIDTH = msrp_pkg::WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  msrp_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output msrp_pkg::out_t    out_data
);

  localparam int SW = $clog2(WIDTH + 1);          // s, m, i counters
  localparam int KW = $clog2(WIDTH);              // shift amount / bit index
  localparam int ZW = $clog2(msrp_pkg::NR_LIMIT) + 1;
  localparam int CW = (WIDTH > ZW) ? WIDTH : ZW;  // compare width for z

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DIV   = 5'd1;
  localparam logic [4:0] S_CHK   = 5'd2;
  localparam logic [4:0] S_EUL   = 5'd3;
  localparam logic [4:0] S_QS    = 5'd4;
  localparam logic [4:0] S_ZCHK  = 5'd5;
  localparam logic [4:0] S_ZEUL  = 5'd6;
  localparam logic [4:0] S_GC    = 5'd7;
  localparam logic [4:0] S_GT    = 5'd8;
  localparam logic [4:0] S_GR    = 5'd9;
  localparam logic [4:0] S_LOOP  = 5'd10;
  localparam logic [4:0] S_SQ    = 5'd11;
  localparam logic [4:0] S_B     = 5'd12;
  localparam logic [4:0] S_B2    = 5'd13;
  localparam logic [4:0] S_RB    = 5'd14;
  localparam logic [4:0] S_TB    = 5'd15;
  localparam logic [4:0] S_FIN   = 5'd16;
  localparam logic [4:0] S_MWAIT = 5'd17;
  localparam logic [4:0] S_PCHK  = 5'd18;
  localparam logic [4:0] S_PMA   = 5'd19;
  localparam logic [4:0] S_PMB   = 5'd20;
  localparam logic [4:0] S_R34   = 5'd21;

  logic [4:0]       state_r, state_nxt;
  logic [4:0]       mret_r, mret_nxt;   // return state after a product
  logic [4:0]       pret_r, pret_nxt;   // return state after a power

  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] p_r, p_nxt;
  logic [WIDTH:0]   rem_r, rem_nxt;     // restoring-division remainder
  logic [KW-1:0]    bit_r, bit_nxt;
  logic [WIDTH-1:0] q_r, q_nxt;
  logic [SW-1:0]    s_r, s_nxt;
  logic [SW-1:0]    m_r, m_nxt;
  logic [SW-1:0]    i_r, i_nxt;
  logic [ZW-1:0]    z_r, z_nxt;
  logic [WIDTH-1:0] c_r, c_nxt;
  logic [WIDTH-1:0] t_r, t_nxt;
  logic [WIDTH-1:0] r_r, r_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;

  // exponentiation registers
  logic [WIDTH-1:0] pbase_r, pbase_nxt;
  logic [WIDTH-1:0] pexp_r, pexp_nxt;
  logic [WIDTH-1:0] pacc_r, pacc_nxt;

  // multiplier operands
  logic [WIDTH-1:0] mx_r, mx_nxt;
  logic [WIDTH-1:0] my_r, my_nxt;
  logic             mstart_r, mstart_nxt;
  logic             mdone;
  logic [WIDTH-1:0] mres;

  // result staging
  logic [WIDTH-1:0] res_root_r, res_root_nxt;
  logic [1:0]       res_st_r, res_st_nxt;

  logic             ovalid_r, ovalid_nxt;
  msrp_pkg::out_t   odata_r, odata_nxt;

  logic             in_fire;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH-1:0] one_w;
  logic [KW-1:0]    bshift;

  assign in_fire = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign one_w    = WIDTH'(1);
  assign rem_sh   = {rem_r[WIDTH-1:0], a_r[bit_r]};
  assign bshift   = KW'(m_r - i_r - 1'b1);

  msrp_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mstart_r),
    .x     (mx_r),
    .y     (my_r),
    .m     (p_r),
    .done  (mdone),
    .res   (mres)
  );

  always_comb begin
    state_nxt    = state_r;
    mret_nxt     = mret_r;
    pret_nxt     = pret_r;
    a_nxt        = a_r;
    p_nxt        = p_r;
    rem_nxt      = rem_r;
    bit_nxt      = bit_r;
    q_nxt        = q_r;
    s_nxt        = s_r;
    m_nxt        = m_r;
    i_nxt        = i_r;
    z_nxt        = z_r;
    c_nxt        = c_r;
    t_nxt        = t_r;
    r_nxt        = r_r;
    b_nxt        = b_r;
    pbase_nxt    = pbase_r;
    pexp_nxt     = pexp_r;
    pacc_nxt     = pacc_r;
    mx_nxt       = mx_r;
    my_nxt       = my_r;
    mstart_nxt   = 1'b0;
    res_root_nxt = res_root_r;
    res_st_nxt   = res_st_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          a_nxt        = in_data.value_in[WIDTH-1:0];
          p_nxt        = in_data.prime_modulus[WIDTH-1:0];
          rem_nxt      = '0;
          bit_nxt      = KW'(WIDTH - 1);
          res_root_nxt = '0;
          res_st_nxt   = msrp_pkg::ST_OK;
          if (in_data.prime_modulus[WIDTH-1:0] < WIDTH'(2)) begin
            res_st_nxt = msrp_pkg::ST_BADMOD;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      // a mod p, one dividend bit per cycle
      S_DIV: begin
        rem_nxt = (rem_sh >= {1'b0, p_r}) ? (rem_sh - {1'b0, p_r}) : rem_sh;
        if (bit_r == '0) begin
          state_nxt = S_CHK;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      S_CHK: begin
        a_nxt = rem_r[WIDTH-1:0];
        if (rem_r[WIDTH-1:0] == '0) begin
          state_nxt = S_FIN;
        end else if (p_r == WIDTH'(2)) begin
          res_root_nxt = rem_r[WIDTH-1:0];
          state_nxt    = S_FIN;
        end else begin
          pbase_nxt = rem_r[WIDTH-1:0];
          pexp_nxt  = (p_r - one_w) >> 1;
          pacc_nxt  = one_w;
          pret_nxt  = S_EUL;
          state_nxt = S_PCHK;
        end
      end
      S_EUL: begin
        if (pacc_r != one_w) begin
          res_st_nxt = msrp_pkg::ST_NONRES;
          state_nxt  = S_FIN;
        end else if (p_r[1:0] == 2'b11) begin
          pbase_nxt = a_r;
          pexp_nxt  = (p_r >> 2) + one_w;
          pacc_nxt  = one_w;
          pret_nxt  = S_R34;
          state_nxt = S_PCHK;
        end else begin
          q_nxt     = p_r - one_w;
          s_nxt     = '0;
          state_nxt = S_QS;
        end
      end
      S_R34: begin
        res_root_nxt = pacc_r;
        state_nxt    = S_FIN;
      end
      // strip factors of two from p-1, one per cycle
      S_QS: begin
        if (q_r != '0 && !q_r[0]) begin
          q_nxt = q_r >> 1;
          s_nxt = s_r + 1'b1;
        end else begin
          z_nxt     = ZW'(2);
          state_nxt = S_ZCHK;
        end
      end
      S_ZCHK: begin
        if (CW'(z_r) >= CW'(p_r) || z_r >= ZW'(msrp_pkg::NR_LIMIT)) begin
          res_st_nxt = msrp_pkg::ST_BADMOD;
          state_nxt  = S_FIN;
        end else begin
          pbase_nxt = WIDTH'(z_r);
          pexp_nxt  = (p_r - one_w) >> 1;
          pacc_nxt  = one_w;
          pret_nxt  = S_ZEUL;
          state_nxt = S_PCHK;
        end
      end
      S_ZEUL: begin
        if (pacc_r == p_r - one_w) begin
          pbase_nxt = WIDTH'(z_r);
          pexp_nxt  = q_r;
          pacc_nxt  = one_w;
          pret_nxt  = S_GC;
          state_nxt = S_PCHK;
        end else begin
          z_nxt     = z_r + 1'b1;
          state_nxt = S_ZCHK;
        end
      end
      S_GC: begin
        c_nxt     = pacc_r;
        pbase_nxt = a_r;
        pexp_nxt  = q_r;
        pacc_nxt  = one_w;
        pret_nxt  = S_GT;
        state_nxt = S_PCHK;
      end
      S_GT: begin
        t_nxt     = pacc_r;
        pbase_nxt = a_r;
        pexp_nxt  = (q_r >> 1) + one_w;
        pacc_nxt  = one_w;
        pret_nxt  = S_GR;
        state_nxt = S_PCHK;
      end
      S_GR: begin
        r_nxt     = pacc_r;
        m_nxt     = s_r;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        i_nxt = SW'(1);
        if (t_r == one_w) begin
          res_root_nxt = r_r;
          state_nxt    = S_FIN;
        end else if (m_r <= SW'(1)) begin
          res_st_nxt = msrp_pkg::ST_BADMOD;
          state_nxt  = S_FIN;
        end else begin
          mx_nxt     = t_r;
          my_nxt     = t_r;
          mstart_nxt = 1'b1;
          mret_nxt   = S_SQ;
          state_nxt  = S_MWAIT;
        end
      end
      // repeated squaring until 1
      S_SQ: begin
        if (mres != one_w) begin
          i_nxt = i_r + 1'b1;
          if (i_r + 1'b1 >= m_r) begin
            res_st_nxt = msrp_pkg::ST_BADMOD;
            state_nxt  = S_FIN;
          end else begin
            mx_nxt     = mres;
            my_nxt     = mres;
            mstart_nxt = 1'b1;
            mret_nxt   = S_SQ;
            state_nxt  = S_MWAIT;
          end
        end else begin
          pbase_nxt = c_r;
          pexp_nxt  = one_w << bshift;
          pacc_nxt  = one_w;
          pret_nxt  = S_B;
          state_nxt = S_PCHK;
        end
      end
      S_B: begin
        b_nxt      = pacc_r;
        mx_nxt     = pacc_r;
        my_nxt     = pacc_r;
        mstart_nxt = 1'b1;
        mret_nxt   = S_B2;
        state_nxt  = S_MWAIT;
      end
      S_B2: begin
        c_nxt      = mres;   // c takes b^2
        mx_nxt     = r_r;
        my_nxt     = b_r;
        mstart_nxt = 1'b1;
        mret_nxt   = S_RB;
        state_nxt  = S_MWAIT;
      end
      S_RB: begin
        r_nxt      = mres;
        mx_nxt     = t_r;
        my_nxt     = c_r;
        mstart_nxt = 1'b1;
        mret_nxt   = S_TB;
        state_nxt  = S_MWAIT;
      end
      S_TB: begin
        t_nxt     = mres;
        m_nxt     = i_r;
        state_nxt = S_LOOP;
      end
      // square-and-multiply, exponent LSB first
      S_PCHK: begin
        if (pexp_r == '0) begin
          state_nxt = pret_r;
        end else if (pexp_r[0]) begin
          mx_nxt     = pacc_r;
          my_nxt     = pbase_r;
          mstart_nxt = 1'b1;
          mret_nxt   = S_PMA;
          state_nxt  = S_MWAIT;
        end else begin
          mx_nxt     = pbase_r;
          my_nxt     = pbase_r;
          mstart_nxt = 1'b1;
          mret_nxt   = S_PMB;
          state_nxt  = S_MWAIT;
        end
      end
      S_PMA: begin
        pacc_nxt   = mres;
        mx_nxt     = pbase_r;
        my_nxt     = pbase_r;
        mstart_nxt = 1'b1;
        mret_nxt   = S_PMB;
        state_nxt  = S_MWAIT;
      end
      S_PMB: begin
        pbase_nxt = mres;
        pexp_nxt  = pexp_r >> 1;
        state_nxt = S_PCHK;
      end
      S_MWAIT: begin
        if (mdone) begin
          state_nxt = mret_r;
        end
      end
      S_FIN: begin
        if (!ovalid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register: loads from S_FIN once the previous result has left
  always_comb begin
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
    if (state_r == S_FIN && (!ovalid_r || !out_stall)) begin
      ovalid_nxt         = 1'b1;
      odata_nxt.root_out = 64'(res_root_r);
      odata_nxt.status   = res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mstart_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mstart_r <= mstart_nxt;
      ovalid_r <= ovalid_nxt;
    end
    mret_r     <= mret_nxt;
    pret_r     <= pret_nxt;
    a_r        <= a_nxt;
    p_r        <= p_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    q_r        <= q_nxt;
    s_r        <= s_nxt;
    m_r        <= m_nxt;
    i_r        <= i_nxt;
    z_r        <= z_nxt;
    c_r        <= c_nxt;
    t_r        <= t_nxt;
    r_r        <= r_nxt;
    b_r        <= b_nxt;
    pbase_r    <= pbase_nxt;
    pexp_r     <= pexp_nxt;
    pacc_r     <= pacc_nxt;
    mx_r       <= mx_nxt;
    my_r       <= my_nxt;
    res_root_r <= res_root_nxt;
    res_st_r   <= res_st_nxt;
    odata_r    <= odata_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

endmodule

### rtl/msrp_checker.sv
// Port-level checks for modular_square_root_prime_top, bound to the top.
// Depends on msrp_pkg.
module msrp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input msrp_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input msrp_pkg::out_t out_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == msrp_pkg::ST_OK ||
                   out_data.status == msrp_pkg::ST_NONRES ||
                   out_data.status == msrp_pkg::ST_BADMOD))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != msrp_pkg::ST_OK |-> out_data.root_out == '0)
    else $error("nonzero root with failure status");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while item in flight");

  // offered transfer holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

endmodule

bind modular_square_root_prime_top msrp_checker u_msrp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### sim/tb_modular_square_root_prime_top.sv
// Testbench for modular_square_root_prime_top: directed table, then random transfers.
// Depends on rtl/msrp_pkg.sv and the block's RTL; results checked against a local model.
`timescale 1ns / 1ps

module tb_modular_square_root_prime_top;

  localparam int          N_RANDOM   = 81;
  localparam int          HOLD_CYC   = 150000;
  localparam int          HOLD_AFTER = 5;
  localparam logic [63:0] P_GOLD     = 64'hFFFF_FFFF_0000_0001;
  localparam logic [63:0] P_TOP      = 64'hFFFF_FFFF_FFFF_FFC5;  // 2^64-59
  localparam logic [63:0] P_M61      = 64'h1FFF_FFFF_FFFF_FFFF;  // 2^61-1

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  msrp_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  msrp_pkg::out_t out_data;

  msrp_pkg::out_t root_q[$];   // expected roots, oldest first
  int   err_cnt;
  int   res_cnt;
  bit   stim_done;

  modular_square_root_prime_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Local model of the block: 128-bit products make the modular
  // multiply trivial, the rest follows Tonelli-Shanks step by step.
  // ---------------------------------------------------------------
  function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] p);
    logic [127:0] prod;
    prod = x * y;
    return 64'(prod % p);
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] p);
    logic [63:0] acc;
    acc = 64'd1 % p;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, b, p);
      b = mul_mod(b, b, p);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic msrp_pkg::out_t sqrt_mod(msrp_pkg::in_t it);
    logic [63:0] a, p, q, s, z, m, c, t, r, i, v, b, b2;
    msrp_pkg::out_t res;
    res = '0;
    res.status = msrp_pkg::ST_OK;
    p = it.prime_modulus;
    a = it.value_in;
    if (p < 2) begin
      res.status = msrp_pkg::ST_BADMOD;
      return res;
    end
    a = a % p;
    if (a == 0) return res;
    if (p == 2) begin
      res.root_out = a;
      return res;
    end
    // Euler's criterion; anything other than exactly 1 is a non-residue
    if (pow_mod(a, (p - 1) >> 1, p) != 1) begin
      res.status = msrp_pkg::ST_NONRES;
      return res;
    end
    if (p[1:0] == 2'd3) begin
      res.root_out = pow_mod(a, (p >> 2) + 1, p);
      return res;
    end
    q = p - 1;
    s = 0;
    while (q != 0 && !q[0]) begin
      q = q >> 1;
      s = s + 1;
    end
    // non-residue search upward from 2, bounded
    z = 2;
    forever begin
      if (z >= p || z >= msrp_pkg::NR_LIMIT) begin
        res.status = msrp_pkg::ST_BADMOD;
        return res;
      end
      if (pow_mod(z, (p - 1) >> 1, p) == p - 1) break;
      z = z + 1;
    end
    m = s;
    c = pow_mod(z, q, p);
    t = pow_mod(a, q, p);
    r = pow_mod(a, (q >> 1) + 1, p);
    while (t != 1) begin
      i = 1;
      if (i >= m) begin
        res.status = msrp_pkg::ST_BADMOD;
        return res;
      end
      v = mul_mod(t, t, p);
      while (v != 1) begin
        i = i + 1;
        if (i >= m) begin
          res.status = msrp_pkg::ST_BADMOD;
          return res;
        end
        v = mul_mod(v, v, p);
      end
      b  = pow_mod(c, 64'd1 << ((m - i - 1) & 64'd63), p);
      b2 = mul_mod(b, b, p);
      r  = mul_mod(r, b, p);
      t  = mul_mod(t, b2, p);
      c  = b2;
      m  = i;
    end
    res.root_out = r;
    return res;
  endfunction

  // ---------------------------------------------------------------
  // Directed table. fixed=1 rows carry their answer; the rest go
  // through the model.
  // ---------------------------------------------------------------
  typedef struct {
    msrp_pkg::in_t  d;
    bit             fixed;
    msrp_pkg::out_t e;
  } dir_row_t;

  dir_row_t dir_tab [19] = '{
    '{'{64'd5, 64'd0},      1'b1, '{64'd0, msrp_pkg::ST_BADMOD}},  // modulus zero
    '{'{64'd5, 64'd1},      1'b1, '{64'd0, msrp_pkg::ST_BADMOD}},  // modulus one
    '{'{64'd0, 64'd97},     1'b1, '{64'd0, msrp_pkg::ST_OK}},      // zero value
    '{'{64'd291, 64'd97},   1'b1, '{64'd0, msrp_pkg::ST_OK}},      // reduces to zero
    '{'{'1, 64'd2},         1'b1, '{64'd1, msrp_pkg::ST_OK}},      // modulus two, odd
    '{'{64'd6, 64'd2},      1'b1, '{64'd0, msrp_pkg::ST_OK}},      // modulus two, even
    '{'{64'd3, 64'd7},      1'b1, '{64'd0, msrp_pkg::ST_NONRES}},  // non-residue
    '{'{64'd2, 64'd7},      1'b1, '{64'd4, msrp_pkg::ST_OK}},      // 3 mod 4
    '{'{64'd1, 64'd9},      1'b1, '{64'd0, msrp_pkg::ST_BADMOD}},  // search fails
    '{'{'1, '1},            1'b1, '{64'd0, msrp_pkg::ST_OK}},      // all ones, self
    '{'{64'd4, 64'd13},     1'b0, '{64'd0, msrp_pkg::ST_OK}},
    '{'{64'd1, 64'd17},     1'b0, '{64'd0, msrp_pkg::ST_OK}},
    '{'{64'd2, 64'd15},     1'b0, '{64'd0, msrp_pkg::ST_OK}},      // composite
    '{'{64'd1, 64'd15},     1'b0, '{64'd0, msrp_pkg::ST_OK}},      // composite, 3 mod 4
    '{'{'1, P_TOP},         1'b0, '{64'd0, msrp_pkg::ST_OK}},
    '{'{'1, P_M61},         1'b0, '{64'd0, msrp_pkg::ST_OK}},
    '{'{64'd49, P_GOLD},    1'b0, '{64'd0, msrp_pkg::ST_OK}},
    '{'{64'd10, 64'd998244353}, 1'b0, '{64'd0, msrp_pkg::ST_OK}},
    '{'{64'hAAAA_5555_0F0F_F0F0, 64'h0000_0000_0001_0001}, 1'b0,
      '{64'd0, msrp_pkg::ST_OK}}
  };

  // primes for the random part: mix of 3 mod 4 and deep 2-adic ones
  logic [63:0] prime_tab [12] = '{
    64'd3, 64'd5, 64'd13, 64'd17, 64'd65537, 64'd998244353, 64'd1000000007,
    64'd1000000009, 64'd4294967291, P_M61, P_TOP, P_GOLD
  };

  function automatic msrp_pkg::in_t rand_item();
    msrp_pkg::in_t it;
    logic [63:0]   p, x;
    int            k;
    k = $urandom_range(0, 99);
    x = {$urandom, $urandom};
    if (k < 75) begin
      p = prime_tab[$urandom_range(0, 11)];
      // well-formed: mostly true squares so the root search runs in full
      if (k < 45) x = mul_mod(x % p, x % p, p);
      it = '{x, p};
    end else if (k < 88) begin
      it = '{x, {$urandom, $urandom}};            // wide, nearly always composite
    end else begin
      it = '{x, 64'($urandom_range(0, 40))};      // small moduli, edge-heavy
    end
    return it;
  endfunction

  // ---------------------------------------------------------------
  // Sender: bursts of transfers with random gaps in between.
  // Each call starts right after a rising edge.
  // ---------------------------------------------------------------
  task automatic send_transfer(msrp_pkg::in_t it, msrp_pkg::out_t exp_res);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    root_q.push_back(exp_res);
  endtask

  task automatic maybe_gap(ref int burst);
    if (burst > 0) begin
      burst--;
    end else begin
      in_valid <= 1'b0;
      in_data  <= '{{$urandom, $urandom}, {$urandom, $urandom}};  // noise while idle
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst = $urandom_range(0, 6);
    end
  endtask

  initial begin
    int            burst;
    msrp_pkg::in_t it;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    stim_done = 1'b0;
    burst     = 3;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[j]) begin
      send_transfer(dir_tab[j].d, dir_tab[j].fixed ? dir_tab[j].e : sqrt_mod(dir_tab[j].d));
      maybe_gap(burst);
    end
    for (int j = 0; j < N_RANDOM; j++) begin
      it = rand_item();
      send_transfer(it, sqrt_mod(it));
      maybe_gap(burst);
    end
    in_valid  <= 1'b0;
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------
  // Receiver: stall pattern changes per mode; one long hold-off
  // early on so the block fills and holds its input off.
  // ---------------------------------------------------------------
  int stall_pct;
  int mode_left;
  int hold_left;
  bit hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      err_cnt   <= 0;
      res_cnt   <= 0;
      stall_pct <= 0;
      mode_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        res_cnt <= res_cnt + 1;
        if (root_q.size() == 0) begin
          $display("%0t: unexpected result root=%h status=%0d", $time,
                   out_data.root_out, out_data.status);
          err_cnt <= err_cnt + 1;
        end else begin
          msrp_pkg::out_t e;
          bit             bad;
          e   = root_q.pop_front();
          bad = 1'b0;
          if (out_data.root_out !== e.root_out) begin
            $display("%0t: root mismatch exp=%h got=%h", $time, e.root_out,
                     out_data.root_out);
            bad = 1'b1;
          end
          if (out_data.status !== e.status) begin
            $display("%0t: status mismatch exp=%0d got=%0d", $time, e.status,
                     out_data.status);
            bad = 1'b1;
          end
          if (bad) err_cnt <= err_cnt + 1;
        end
      end

      if (!hold_done && res_cnt == HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYC;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left > 1);
      end else begin
        if (mode_left == 0) begin
          // quiet stretch, light, or heavy stalling
          case ($urandom_range(0, 2))
            0:       stall_pct <= 0;
            1:       stall_pct <= 30;
            default: stall_pct <= 90;
          endcase
          mode_left <= $urandom_range(20, 3000);
        end else begin
          mode_left <= mode_left - 1;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // end of run: drain, settle, report
  initial begin
    wait (stim_done);
    while (root_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (err_cnt == 0 && root_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #(3.0e9);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
